@@ src/camera_data_package_receiver_defines.svh @@
// assertion macros used by the receiver back end
`ifndef CAMERA_DATA_PACKAGE_RECEIVER_DEFINES_SVH
`define CAMERA_DATA_PACKAGE_RECEIVER_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define CDPR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cdpr check failed in the same cycle");

// condition must hold in the cycle after the trigger
`define CDPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cdpr check failed one cycle later");

`endif

@@ src/cdpr_pkg.sv @@
package cdpr_pkg;

   // field widths of the channels
   localparam int OPCODE_W = 1;
   localparam int TOTAL_W  = 24;
   localparam int BYTE_W   = 8;
   localparam int KIND_W   = 2;
   localparam int ACK_W    = 16;
   localparam int ADDR_W   = 24;
   localparam int PSIZE_W  = 16;

   // protocol constants
   localparam int              PKT_OVERHEAD = 6;
   localparam logic [ACK_W-1:0] FINAL_ACK   = 16'hF0F0;

   // decoupling queue depth
   localparam int QUEUE_DEPTH = 2;

   // opcodes of the request channel
   localparam logic [OPCODE_W-1:0] OP_START = 1'b0;
   localparam logic [OPCODE_W-1:0] OP_BYTE  = 1'b1;

   // result kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_ACK            = 2'd0,
      KIND_WRITE          = 2'd1,
      KIND_CHECKSUM_ERROR = 2'd2,
      KIND_SIZE_ERROR     = 2'd3
   } kind_type;

   // classified command carried through the queue
   typedef struct packed {
      logic               is_start;
      logic [TOTAL_W-1:0] total_bytes;
      logic [BYTE_W-1:0]  rx_byte;
   } cmd_type;

   // head of the queue as seen by the back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

   // one result transaction
   typedef struct packed {
      kind_type          kind;
      logic [ACK_W-1:0]  ack_id;
      logic [ADDR_W-1:0] write_address;
      logic [BYTE_W-1:0] write_data;
      logic              last;
   } rsp_type;

endpackage

@@ src/cdpr_req_if.sv @@
interface cdpr_req_if;
   import cdpr_pkg::*;

   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [TOTAL_W-1:0]  total_bytes;
   logic [BYTE_W-1:0]   rx_byte;

   modport source (output valid, output opcode, output total_bytes, output rx_byte,
                   input ready);
   modport sink (input valid, input opcode, input total_bytes, input rx_byte,
                 output ready);
endinterface

@@ src/cdpr_rsp_if.sv @@
interface cdpr_rsp_if;
   import cdpr_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [ACK_W-1:0]  ack_id;
   logic [ADDR_W-1:0] write_address;
   logic [BYTE_W-1:0] write_data;
   logic              last;

   modport source (output valid, output kind, output ack_id, output write_address,
                   output write_data, output last, input ready);
   modport sink (input valid, input kind, input ack_id, input write_address,
                 input write_data, input last, output ready);
endinterface

@@ src/cdpr_front.sv @@
module cdpr_front (
   cdpr_req_if.sink            req,
   input  logic                queue_ready,
   output logic                queue_push,
   output cdpr_pkg::cmd_type   queue_cmd
);
   import cdpr_pkg::*;

   // accept whenever the queue has room
   assign req.ready  = queue_ready;
   assign queue_push = req.valid && queue_ready;

   // classify the transaction into a command
   always_comb begin
      queue_cmd.is_start    = (req.opcode == OP_START);
      queue_cmd.total_bytes = req.total_bytes;
      queue_cmd.rx_byte     = req.rx_byte;
   end
endmodule

@@ src/cdpr_queue.sv @@
module cdpr_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  cdpr_pkg::cmd_type        push_cmd,
   output logic                     push_ready,
   input  logic                     pop,
   output cdpr_pkg::queue_head_type head
);
   import cdpr_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign do_push    = push && push_ready;
   assign do_pop     = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.cmd   = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end
endmodule

@@ src/cdpr_back.sv @@
`include "camera_data_package_receiver_defines.svh"

module cdpr_back #(
   parameter int PACKAGE_BUFFER = 512,
   parameter int SIZE_BITS      = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cdpr_pkg::queue_head_type head,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output cdpr_pkg::rsp_type        rsp_data
);
   import cdpr_pkg::*;

   localparam int IDX_W = $clog2(PACKAGE_BUFFER);
   localparam int CNT_W = SIZE_BITS + 1;
   localparam logic [PSIZE_W-1:0] MAX_PAYLOAD = PSIZE_W'(PACKAGE_BUFFER - PKT_OVERHEAD);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HDR0,
      PH_HDR1,
      PH_HDR2,
      PH_HDR3,
      PH_PAYLOAD,
      PH_CHK_LO,
      PH_CHK_HI
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [PSIZE_W-1:0]     size_ff, size_in;
   logic [IDX_W-1:0]       index_ff, index_in;
   logic [BYTE_W-1:0]      sum_ff, sum_in;
   logic [BYTE_W-1:0]      chk_low_ff, chk_low_in;
   logic [CNT_W-1:0]       received_ff, received_in;
   logic [ACK_W-1:0]       count_ff, count_in;
   logic [SIZE_BITS-1:0]   expected_ff, expected_in;
   logic                   out_valid_ff, out_valid_in;
   rsp_type                out_ff, out_in;

   logic                   step;
   logic                   res_valid;
   rsp_type                res;
   logic [BYTE_W-1:0]      b;
   logic [CNT_W-1:0]       addr;
   logic [CNT_W-1:0]       received_sum;
   logic [IDX_W-1:0]       index_next;
   logic [PSIZE_W-1:0]     size_full;
   logic [ACK_W-1:0]       count_next;

   // take the queue head when the output slot is free or draining
   assign step = head.valid && (!out_valid_ff || rsp_ready);
   assign pop  = step;
   assign b    = head.cmd.rx_byte;

   assign addr         = received_ff + CNT_W'(index_ff);
   assign received_sum = received_ff + CNT_W'(size_ff);
   assign index_next   = index_ff + 1'b1;
   assign size_full    = size_ff | {b, 8'h00};
   assign count_next   = count_ff + 1'b1;

   // package parser
   always_comb begin
      phase_in    = phase_ff;
      size_in     = size_ff;
      index_in    = index_ff;
      sum_in      = sum_ff;
      chk_low_in  = chk_low_ff;
      received_in = received_ff;
      count_in    = count_ff;
      expected_in = expected_ff;
      res_valid   = 1'b0;
      res         = '0;
      if (step) begin
         if (head.cmd.is_start) begin
            expected_in = SIZE_BITS'(head.cmd.total_bytes);
            received_in = '0;
            count_in    = '0;
            size_in     = '0;
            index_in    = '0;
            sum_in      = '0;
            chk_low_in  = '0;
            phase_in    = PH_HDR0;
            res_valid   = 1'b1;
            res.kind    = KIND_ACK;
         end else begin
            case (phase_ff)
               PH_IDLE: begin
               end
               PH_HDR0, PH_HDR1: begin
                  sum_in   = sum_ff + b;
                  phase_in = (phase_ff == PH_HDR0) ? PH_HDR1 : PH_HDR2;
               end
               PH_HDR2: begin
                  sum_in   = sum_ff + b;
                  size_in  = PSIZE_W'(b);
                  phase_in = PH_HDR3;
               end
               PH_HDR3: begin
                  sum_in   = sum_ff + b;
                  size_in  = size_full;
                  index_in = '0;
                  if (size_full > MAX_PAYLOAD) begin
                     phase_in  = PH_IDLE;
                     res_valid = 1'b1;
                     res.kind  = KIND_SIZE_ERROR;
                     res.last  = 1'b1;
                  end else begin
                     phase_in = (size_full == '0) ? PH_CHK_LO : PH_PAYLOAD;
                  end
               end
               PH_PAYLOAD: begin
                  sum_in   = sum_ff + b;
                  index_in = index_next;
                  if (PSIZE_W'(index_next) >= size_ff) begin
                     phase_in = PH_CHK_LO;
                  end
                  // writes past the image are dropped
                  if (addr < CNT_W'(expected_ff)) begin
                     res_valid         = 1'b1;
                     res.kind          = KIND_WRITE;
                     res.write_address = ADDR_W'(addr);
                     res.write_data    = b;
                  end
               end
               PH_CHK_LO: begin
                  chk_low_in = b;
                  phase_in   = PH_CHK_HI;
               end
               PH_CHK_HI: begin
                  res_valid = 1'b1;
                  if ((b != '0) || (chk_low_ff != sum_ff)) begin
                     phase_in = PH_IDLE;
                     res.kind = KIND_CHECKSUM_ERROR;
                     res.last = 1'b1;
                  end else begin
                     received_in = received_sum;
                     if (received_sum >= CNT_W'(expected_ff)) begin
                        phase_in   = PH_IDLE;
                        res.kind   = KIND_ACK;
                        res.ack_id = FINAL_ACK;
                        res.last   = 1'b1;
                     end else begin
                        count_in   = count_next;
                        phase_in   = PH_HDR0;
                        sum_in     = '0;
                        index_in   = '0;
                        res.kind   = KIND_ACK;
                        res.ack_id = count_next;
                     end
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (step && res_valid) begin
         out_valid_in = 1'b1;
         out_in       = res;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         size_ff      <= '0;
         index_ff     <= '0;
         sum_ff       <= '0;
         chk_low_ff   <= '0;
         received_ff  <= '0;
         count_ff     <= '0;
         expected_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         size_ff      <= size_in;
         index_ff     <= index_in;
         sum_ff       <= sum_in;
         chk_low_ff   <= chk_low_in;
         received_ff  <= received_in;
         count_ff     <= count_in;
         expected_ff  <= expected_in;
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // checks
   `CDPR_ASSERT_NEXT(a_start_to_header, clock, reset, step && head.cmd.is_start, phase_ff == PH_HDR0)
   `CDPR_ASSERT_NOW(a_index_in_range, clock, reset, phase_ff == PH_PAYLOAD, PSIZE_W'(index_ff) < size_ff)
   `CDPR_ASSERT_NOW(a_write_not_last, clock, reset, out_valid_ff && out_ff.kind == KIND_WRITE, !out_ff.last)
   `CDPR_ASSERT_NOW(a_error_ends_idle, clock, reset, step && res_valid && res.last, phase_in == PH_IDLE)
endmodule

@@ src/camera_data_package_receiver.sv @@
// Camera data package receiver. A start transaction latches the expected image size and
// answers with a request for package 0; byte transactions then walk each package through a
// 4-byte header, the payload and a 2-byte checksum. Payload bytes come out at once as writes
// at the image offset, so the writes of a package that ends in a checksum or size error must
// be treated as invalid by the consumer. Every transaction yields zero or one result. The
// block accepts one transaction per clock cycle sustained while results are taken: a
// two-entry queue sits between the decoding front end and the parser, and the parser updates
// its state as each byte is popped. An accepted transaction is registered in a queue entry,
// and its result in the output register, where it is held; while it waits to be taken the
// parser holds, and the queue takes at most two more transactions before the input stalls.
module camera_data_package_receiver #(
   parameter int PACKAGE_BUFFER = 512,
   parameter int SIZE_BITS      = 24
) (
   input logic        clock,
   input logic        reset,
   cdpr_req_if.sink   req,
   cdpr_rsp_if.source rsp
);
   import cdpr_pkg::*;

   logic           queue_ready;
   logic           queue_push;
   cmd_type        queue_cmd;
   logic           queue_pop;
   queue_head_type queue_head;
   logic           back_valid;
   rsp_type        back_data;

   // decode and accept
   cdpr_front u_front (
      .req         (req),
      .queue_ready (queue_ready),
      .queue_push  (queue_push),
      .queue_cmd   (queue_cmd)
   );

   // decoupling queue
   cdpr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_cmd   (queue_cmd),
      .push_ready (queue_ready),
      .pop        (queue_pop),
      .head       (queue_head)
   );

   // package parser and result register
   cdpr_back #(
      .PACKAGE_BUFFER (PACKAGE_BUFFER),
      .SIZE_BITS      (SIZE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (queue_head),
      .pop       (queue_pop),
      .rsp_valid (back_valid),
      .rsp_ready (rsp.ready),
      .rsp_data  (back_data)
   );

   // result channel
   assign rsp.valid         = back_valid;
   assign rsp.kind          = back_data.kind;
   assign rsp.ack_id        = back_data.ack_id;
   assign rsp.write_address = back_data.write_address;
   assign rsp.write_data    = back_data.write_data;
   assign rsp.last          = back_data.last;
endmodule
